@@ design/jsu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper: channel payloads,
// the job record passed from the parser front end to the byte serialiser.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // input and result payloads
    typedef struct packed {
        logic [7:0] in_byte;
        logic       token_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic        is_terminator;
        logic [15:0] token_length;
    } out_item_t;

    // code points never exceed 21 bits, even for an unpaired low surrogate
    localparam int CP_BITS = 21;

    // one job: the bytes (0 to 4) and the optional terminator caused by one input byte
    typedef struct packed {
        logic [CP_BITS-1:0] cp;      // code point, or the raw byte when nbytes is one
        logic [2:0]         nbytes;
        logic               term;
        logic [15:0]        len;
    } job_t;

    // job queue
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // escape characters
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    localparam logic [7:0] BYTE_BS = 8'h08;
    localparam logic [7:0] BYTE_FF = 8'h0C;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_HT = 8'h09;

    localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
    localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
    // 0x10000 - 0xDC00, the fixed part of the pair combination
    localparam logic [CP_BITS-1:0] SURR_OFFSET = 21'h02400;

endpackage

`default_nettype wire

@@ design/jsu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Parser front end: takes one string byte per transfer, tracks escapes, hex
// runs and UTF-8 continuations, and issues one job per byte that has output.
// ----------------------------------------------------------------------------
module jsu_front #(
    parameter int LENGTH_COUNT_BITS = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_accept,
    input  wire jsu_pkg::in_item_t in_item,
    output logic                  push,
    output jsu_pkg::job_t         job
);
    import jsu_pkg::*;

    localparam int LB = LENGTH_COUNT_BITS;

    typedef enum logic [6:0] {
        MODE_PLAIN   = 7'b0000001,
        MODE_ESC     = 7'b0000010,
        MODE_HEX_HI  = 7'b0000100,
        MODE_SKIP_BS = 7'b0001000,
        MODE_SKIP_U  = 7'b0010000,
        MODE_HEX_LO  = 7'b0100000,
        MODE_CONT    = 7'b1000000
    } mode_t;

    function automatic logic [3:0] hex_value(input logic [7:0] d);
        logic [7:0] v;
        if (d >= 8'h61) begin
            v = d - 8'h57;
        end else if (d >= 8'h41) begin
            v = d - 8'h37;
        end else begin
            v = d - 8'h30;
        end
        return v[3:0];
    endfunction

    function automatic logic [2:0] enc_len(input logic [CP_BITS-1:0] cp);
        if (cp < 21'h00080) begin
            return 3'd1;
        end else if (cp < 21'h00800) begin
            return 3'd2;
        end else if (cp < 21'h10000) begin
            return 3'd3;
        end else begin
            return 3'd4;
        end
    endfunction

    // number of continuation bytes after a lead byte, zero beyond three
    function automatic logic [1:0] lead_cont(input logic [7:0] b);
        if (!b[6]) begin
            return 2'd0;
        end else if (!b[5]) begin
            return 2'd1;
        end else if (!b[4]) begin
            return 2'd2;
        end else if (!b[3]) begin
            return 2'd3;
        end else begin
            return 2'd0;
        end
    endfunction

    mode_t        mode_reg, mode_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [15:0]  high_reg, high_next;
    logic [15:0]  low_reg, low_next;
    logic [1:0]   cont_reg, cont_next;
    logic [LB-1:0] count_reg, count_next;

    logic [7:0]          b;
    logic [3:0]          hv;
    logic [15:0]         high_cat;
    logic [15:0]         low_cat;
    logic [CP_BITS-1:0]  sur_cp;
    logic [CP_BITS-1:0]  job_cp;
    logic [2:0]          job_n;
    logic [LB:0]         sum;
    logic [LB-1:0]       count_sat;
    logic [LB+15:0]      count_ext;

    assign b        = in_item.in_byte;
    assign hv       = hex_value(b);
    assign high_cat = {high_reg[11:0], hv};
    assign low_cat  = {low_reg[11:0], hv};
    // high unit is known to be in the high surrogate range here
    assign sur_cp   = {1'b0, high_reg[9:0], 10'b0} + {5'b0, low_cat} + SURR_OFFSET;

    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        high_next = high_reg;
        low_next  = low_reg;
        cont_next = cont_reg;
        job_cp    = '0;
        job_n     = 3'd0;
        if (in_accept) begin
            case (mode_reg)
                MODE_ESC: begin
                    mode_next = MODE_PLAIN;
                    job_n     = 3'd1;
                    case (b)
                        CH_QUOTE:     job_cp = {13'b0, CH_QUOTE};
                        CH_SLASH:     job_cp = {13'b0, CH_SLASH};
                        CH_BACKSLASH: job_cp = {13'b0, CH_BACKSLASH};
                        CH_LOWER_B:   job_cp = {13'b0, BYTE_BS};
                        CH_LOWER_F:   job_cp = {13'b0, BYTE_FF};
                        CH_LOWER_N:   job_cp = {13'b0, BYTE_LF};
                        CH_LOWER_R:   job_cp = {13'b0, BYTE_CR};
                        CH_LOWER_T:   job_cp = {13'b0, BYTE_HT};
                        default: begin
                            // anything else opens a four digit hex run
                            job_n     = 3'd0;
                            mode_next = MODE_HEX_HI;
                            cnt_next  = 2'd0;
                            high_next = '0;
                        end
                    endcase
                end
                MODE_HEX_HI: begin
                    high_next = high_cat;
                    cnt_next  = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        if (high_cat >= SURR_HIGH_MIN && high_cat <= SURR_HIGH_MAX) begin
                            mode_next = MODE_SKIP_BS;
                        end else begin
                            mode_next = MODE_PLAIN;
                            job_cp    = {5'b0, high_cat};
                            job_n     = enc_len({5'b0, high_cat});
                        end
                    end
                end
                MODE_SKIP_BS: begin
                    mode_next = MODE_SKIP_U;
                end
                MODE_SKIP_U: begin
                    mode_next = MODE_HEX_LO;
                    cnt_next  = 2'd0;
                    low_next  = '0;
                end
                MODE_HEX_LO: begin
                    low_next = low_cat;
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3) begin
                        mode_next = MODE_PLAIN;
                        job_cp    = sur_cp;
                        job_n     = enc_len(sur_cp);
                    end
                end
                MODE_CONT: begin
                    job_cp    = {13'b0, b};
                    job_n     = 3'd1;
                    cont_next = cont_reg - 2'd1;
                    if (cont_reg == 2'd1) begin
                        mode_next = MODE_PLAIN;
                    end
                end
                default: begin
                    mode_next = MODE_PLAIN;
                    if (b == CH_BACKSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        job_cp = {13'b0, b};
                        job_n  = 3'd1;
                        if (b[7]) begin
                            cont_next = lead_cont(b);
                            if (lead_cont(b) != 2'd0) begin
                                mode_next = MODE_CONT;
                            end
                        end
                    end
                end
            endcase
            if (in_item.token_end) begin
                // open escapes and continuations are dropped at token end
                mode_next = MODE_PLAIN;
                cnt_next  = 2'd0;
                cont_next = 2'd0;
            end
        end
    end

    // saturating byte count, at most four added per transfer
    assign sum       = {1'b0, count_reg} + (LB+1)'(job_n);
    assign count_sat = sum[LB] ? {LB{1'b1}} : sum[LB-1:0];
    assign count_ext = {16'b0, count_sat};

    always_comb begin
        count_next = count_reg;
        if (in_accept) begin
            count_next = in_item.token_end ? '0 : count_sat;
        end
    end

    assign push       = in_accept && (job_n != 3'd0 || in_item.token_end);
    assign job.cp     = job_cp;
    assign job.nbytes = job_n;
    assign job.term   = in_item.token_end;
    assign job.len    = count_ext[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PLAIN;
            cnt_reg   <= '0;
            high_reg  <= '0;
            low_reg   <= '0;
            cont_reg  <= '0;
            count_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            high_reg  <= high_next;
            low_reg   <= low_next;
            cont_reg  <= cont_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/jsu_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_queue
// Short job queue between the parser and the serialiser; the head entry is
// visible to the serialiser until it is popped.
// ----------------------------------------------------------------------------
module jsu_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire jsu_pkg::job_t push_job,
    input  wire logic          pop,
    output logic               full,
    output logic               not_empty,
    output jsu_pkg::job_t      head
);
    import jsu_pkg::*;

    localparam logic [QUEUE_AW:0]   FULL_COUNT = (QUEUE_AW+1)'(QUEUE_DEPTH);
    localparam logic [QUEUE_AW-1:0] PTR_ONE    = QUEUE_AW'(1);
    localparam logic [QUEUE_AW:0]   CNT_ONE    = (QUEUE_AW+1)'(1);

    job_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_ONE : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_ONE;
        end else if (pop && !push) begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ design/jsu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// Serialiser: walks the head job one result per cycle unless stalled, UTF-8
// encoding the code point plus the terminator into a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          job_valid,
    input  wire jsu_pkg::job_t job,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output jsu_pkg::out_item_t m_data
);
    import jsu_pkg::*;

    function automatic logic [7:0] enc_byte(input logic [CP_BITS-1:0] cp,
                                            input logic [2:0] n,
                                            input logic [1:0] idx);
        logic [7:0] r;
        r = cp[7:0];
        case (n)
            3'd2: begin
                r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            end
            3'd3: begin
                case (idx)
                    2'd0:    r = {4'b1110, cp[15:12]};
                    2'd1:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            3'd4: begin
                case (idx)
                    2'd0:    r = {5'b11110, cp[20:18]};
                    2'd1:    r = {2'b10, cp[17:12]};
                    2'd2:    r = {2'b10, cp[11:6]};
                    default: r = {2'b10, cp[5:0]};
                endcase
            end
            default: r = cp[7:0];
        endcase
        return r;
    endfunction

    logic [2:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;

    logic [2:0] total;
    logic       last;
    logic       term_now;
    logic       take;

    assign total    = job.nbytes + {2'b0, job.term};
    assign last     = (idx_reg == total - 3'd1);
    assign term_now = job.term && (idx_reg == job.nbytes);
    assign take     = job_valid && (!m_valid_reg || m_ready);
    assign pop      = take && last;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (take) begin
            m_valid_next              = 1'b1;
            m_data_next.last_of_run   = last;
            m_data_next.is_terminator = term_now;
            if (term_now) begin
                m_data_next.out_byte     = '0;
                m_data_next.token_length = job.len;
            end else begin
                m_data_next.out_byte     = enc_byte(job.cp, job.nbytes, idx_reg[1:0]);
                m_data_next.token_length = '0;
            end
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ design/json_string_unescape_to_utf8_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_to_utf8_top
// Unescapes a JSON string body byte stream into UTF-8 bytes and closes each
// token with a terminator result that carries the saturating byte count.
// ----------------------------------------------------------------------------
//  port group  | direction | payload
//  s_*         | in        | in_item_t  : in_byte, token_end
//  m_*         | out       | out_item_t : out_byte, last_of_run, is_terminator,
//              |           |              token_length
//
//  one input byte per cycle while s_ready is high; the parser finishes each byte
//  in the cycle it is taken and queues its job, the serialiser emits one result
//  per cycle unless m_ready stalls it; an input byte causing k results (k <= 5)
//  holds the serialiser until all k are out; results leave via the output register
//  s_ready drops only while the four entry job queue is full
//  synchronous reset clears parser state, queue and output stage at once
// ----------------------------------------------------------------------------
module json_string_unescape_to_utf8_top #(
    parameter int LENGTH_COUNT_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire jsu_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output jsu_pkg::out_item_t     m_data
);
    import jsu_pkg::*;

    logic q_full;
    logic q_not_empty;
    logic q_push;
    logic q_pop;
    job_t new_job;
    job_t head_job;
    logic in_accept;

    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    jsu_front #(
        .LENGTH_COUNT_BITS(LENGTH_COUNT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_item   (s_data),
        .push      (q_push),
        .job       (new_job)
    );

    jsu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (new_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    jsu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_not_empty),
        .job       (head_job),
        .pop       (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

@@ design/jsu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_checker
// Port level checks of the unescaper's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module jsu_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire jsu_pkg::in_item_t  s_data,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire jsu_pkg::out_item_t m_data
);
    import jsu_pkg::*;

    // a stalled result transfer keeps its content
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // the terminator always closes the run of its input byte
    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_terminator |-> m_data.last_of_run)
        else $error("terminator not marked last");

    // terminator carries no byte, ordinary bytes carry no length
    a_field_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_terminator ? (m_data.out_byte == 8'h00)
                                          : (m_data.token_length == 16'h0000)))
        else $error("byte and length fields mixed");

    // an accepted token end forbids a terminator transfer that is not last of its run
    a_term_order: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.token_end |=> !(m_valid && m_ready
            && m_data.is_terminator && !m_data.last_of_run))
        else $error("terminator out of order");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind json_string_unescape_to_utf8_top jsu_checker u_jsu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JSON string unescaper. A directed table covers
// the extremes, an escape, a surrogate pair and the token end cases. It is
// followed by random well-formed runs mixed with noise under three idling
// profiles. A decoder predictor works out each result not typed in the table,
// and the monitor compares each result transfer with the oldest expected one.
// ----------------------------------------------------------------------------
module testbench;
    import jsu_pkg::*;

    localparam int LEN_BITS    = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        PM_PLAIN, PM_ESCAPE, PM_HEX_HIGH, PM_SKIP_BSLASH, PM_SKIP_U, PM_HEX_LOW, PM_CONT
    } parse_mode_e;

    // directed row: stimulus plus up to two results typed in by hand
    typedef struct packed {
        in_item_t   stim;
        logic [1:0] n_typed;
        out_item_t  t0;
        out_item_t  t1;
    } dir_row_t;

    localparam out_item_t NO_RES = '0;
    localparam logic [7:0] ESCAPE_CHARS [8] = '{
        CH_QUOTE, CH_SLASH, CH_BACKSLASH, CH_LOWER_B,
        CH_LOWER_F, CH_LOWER_N, CH_LOWER_R, CH_LOWER_T
    };

    dir_row_t dir_table [25] = '{
        '{'{8'h41, 1'b0}, 2'd1, '{8'h41, 1'b1, 1'b0, 16'd0}, NO_RES},
        '{'{8'h00, 1'b0}, 2'd1, '{8'h00, 1'b1, 1'b0, 16'd0}, NO_RES},
        '{'{8'h7F, 1'b0}, 2'd1, '{8'h7F, 1'b1, 1'b0, 16'd0}, NO_RES},
        '{'{CH_BACKSLASH, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{CH_LOWER_N, 1'b0}, 2'd1, '{BYTE_LF, 1'b1, 1'b0, 16'd0}, NO_RES},
        // \uD83D\uDE00 with a non-hex digit standing in for a zero
        '{'{CH_BACKSLASH, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h75, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h44, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h38, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h33, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h44, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{CH_BACKSLASH, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h75, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h44, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h45, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h67, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h30, 1'b0}, 2'd0, NO_RES, NO_RES},
        // lead bytes: too many ones, three continuations, none
        '{'{8'hFF, 1'b0}, 2'd1, '{8'hFF, 1'b1, 1'b0, 16'd0}, NO_RES},
        '{'{8'hF0, 1'b0}, 2'd1, '{8'hF0, 1'b1, 1'b0, 16'd0}, NO_RES},
        '{'{8'h9F, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h98, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h80, 1'b0}, 2'd0, NO_RES, NO_RES},
        '{'{8'h80, 1'b0}, 2'd1, '{8'h80, 1'b1, 1'b0, 16'd0}, NO_RES},
        // escape left open at the token end is dropped
        '{'{CH_BACKSLASH, 1'b1}, 2'd1, '{8'h00, 1'b1, 1'b1, 16'd14}, NO_RES},
        '{'{8'h5A, 1'b1}, 2'd2, '{8'h5A, 1'b0, 1'b0, 16'd0}, '{8'h00, 1'b1, 1'b1, 16'd1}}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int tx_idle_pct = 9;
    int rx_idle_pct = 54;
    int mismatches  = 0;
    int cycle_count = 0;
    int hold_left   = 0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    // decoder state of the predictor
    parse_mode_e         pm        = PM_PLAIN;
    logic [1:0]          hex_cnt   = '0;
    logic [15:0]         high_cu   = '0;
    logic [15:0]         low_cu    = '0;
    logic [1:0]          cont_left = '0;
    logic [LEN_BITS-1:0] byte_count = '0;

    out_item_t step_res [$];
    out_item_t utf8_expected [$];
    dir_row_t  typed_rows [$];

    always #4 aclk = ~aclk;

    json_string_unescape_to_utf8_top #(
        .LENGTH_COUNT_BITS(LEN_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic void emit_byte(logic [7:0] b);
        step_res.push_back(out_item_t'{b, 1'b0, 1'b0, 16'd0});
        if (byte_count != {LEN_BITS{1'b1}})
            byte_count = byte_count + 1'b1;
    endfunction

    function automatic void emit_cp(logic [31:0] cp);
        if (cp < 32'h80) begin
            emit_byte(cp[7:0]);
        end else if (cp < 32'h800) begin
            emit_byte(8'(cp >> 6) | 8'hC0);
            emit_byte({2'b10, cp[5:0]});
        end else if (cp < 32'h10000) begin
            emit_byte(8'(cp >> 12) | 8'hE0);
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
        end else begin
            emit_byte(8'(cp >> 18) | 8'hF0);
            emit_byte({2'b10, cp[17:12]});
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
        end
    endfunction

    // anything that is not a hex digit still yields a nibble, computed as in the front end
    function automatic logic [3:0] hex_nibble(logic [7:0] d);
        logic [7:0] v;
        if (d >= "a")
            v = d - "a" + 8'd10;
        else if (d >= "A")
            v = d - "A" + 8'd10;
        else
            v = d - "0";
        return v[3:0];
    endfunction

    function automatic logic [1:0] lead_cont(logic [7:0] b);
        int k;
        k = 0;
        for (int i = 6; i >= 0 && b[i]; i--)
            k++;
        return (k <= 3) ? 2'(k) : 2'd0;
    endfunction

    function automatic void decode_byte(in_item_t it);
        logic [7:0]  b;
        logic [31:0] cp;
        b = it.in_byte;
        step_res = {};
        case (pm)
            PM_ESCAPE: begin
                pm = PM_PLAIN;
                case (b)
                    CH_QUOTE, CH_SLASH, CH_BACKSLASH: emit_byte(b);
                    CH_LOWER_B: emit_byte(BYTE_BS);
                    CH_LOWER_F: emit_byte(BYTE_FF);
                    CH_LOWER_N: emit_byte(BYTE_LF);
                    CH_LOWER_R: emit_byte(BYTE_CR);
                    CH_LOWER_T: emit_byte(BYTE_HT);
                    default: begin
                        pm      = PM_HEX_HIGH;
                        hex_cnt = 2'd0;
                        high_cu = 16'd0;
                    end
                endcase
            end
            PM_HEX_HIGH: begin
                high_cu = {high_cu[11:0], hex_nibble(b)};
                if (hex_cnt == 2'd3) begin
                    hex_cnt = 2'd0;
                    if (high_cu >= SURR_HIGH_MIN && high_cu <= SURR_HIGH_MAX) begin
                        pm = PM_SKIP_BSLASH;
                    end else begin
                        pm = PM_PLAIN;
                        emit_cp({16'd0, high_cu});
                    end
                end else begin
                    hex_cnt = hex_cnt + 2'd1;
                end
            end
            PM_SKIP_BSLASH: pm = PM_SKIP_U;
            PM_SKIP_U: begin
                pm      = PM_HEX_LOW;
                hex_cnt = 2'd0;
                low_cu  = 16'd0;
            end
            PM_HEX_LOW: begin
                low_cu = {low_cu[11:0], hex_nibble(b)};
                if (hex_cnt == 2'd3) begin
                    // wraps like the hardware for a bad low half
                    cp = ({16'd0, high_cu} - 32'hD800) << 10;
                    cp = cp + {16'd0, low_cu} - 32'hDC00 + 32'h10000;
                    hex_cnt = 2'd0;
                    pm      = PM_PLAIN;
                    emit_cp(cp);
                end else begin
                    hex_cnt = hex_cnt + 2'd1;
                end
            end
            PM_CONT: begin
                emit_byte(b);
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    pm = PM_PLAIN;
            end
            default: begin
                pm = PM_PLAIN;
                if (b == CH_BACKSLASH) begin
                    pm = PM_ESCAPE;
                end else begin
                    emit_byte(b);
                    if (b[7]) begin
                        cont_left = lead_cont(b);
                        if (cont_left != 2'd0)
                            pm = PM_CONT;
                    end
                end
            end
        endcase
        if (it.token_end) begin
            step_res.push_back(out_item_t'{8'h00, 1'b0, 1'b1, 16'(byte_count)});
            pm         = PM_PLAIN;
            hex_cnt    = 2'd0;
            cont_left  = 2'd0;
            byte_count = '0;
        end
        if (step_res.size() != 0)
            step_res[step_res.size()-1].last_of_run = 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v, got_v);
        if (want_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // predict on each input transfer, then check each result transfer
    always @(posedge aclk) begin : monitor
        dir_row_t  row;
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_byte(s_data);
                if (typed_rows.size() != 0) begin
                    row = typed_rows.pop_front();
                    if (row.n_typed != 2'd0) begin
                        step_res = {};
                        step_res.push_back(row.t0);
                        if (row.n_typed == 2'd2)
                            step_res.push_back(row.t1);
                    end
                end
                foreach (step_res[k])
                    utf8_expected.push_back(step_res[k]);
            end
            if (m_valid && m_ready) begin
                if (utf8_expected.size() == 0) begin
                    $error("result transfer with nothing predicted: 0x%0h", m_data);
                    mismatches++;
                end else begin
                    want = utf8_expected.pop_front();
                    check_field("out_byte", want.out_byte, m_data.out_byte);
                    check_field("last_of_run", want.last_of_run, m_data.last_of_run);
                    check_field("is_terminator", want.is_terminator, m_data.is_terminator);
                    check_field("token_length", want.token_length, m_data.token_length);
                end
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input in_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // sender stops until every predicted result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (utf8_expected.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic void push_u_escape(ref in_item_t run [$], input logic [15:0] unit);
        logic [3:0] v;
        run.push_back(in_item_t'{CH_BACKSLASH, 1'b0});
        run.push_back(in_item_t'{8'h75, 1'b0});
        for (int i = 3; i >= 0; i--) begin
            v = unit[4*i +: 4];
            if (v < 4'd10)
                run.push_back(in_item_t'{8'h30 + 8'(v), 1'b0});
            else if ($urandom_range(1) == 0)
                run.push_back(in_item_t'{8'h61 + 8'(v) - 8'd10, 1'b0});
            else
                run.push_back(in_item_t'{8'h41 + 8'(v) - 8'd10, 1'b0});
        end
    endfunction

    // mostly well-formed runs with random content, some noise and cut tokens
    task automatic random_tokens(input int n_items);
        in_item_t    run [$];
        int          sent;
        int          kind;
        int          cut;
        logic [15:0] unit;
        logic [7:0]  b;
        sent = 0;
        while (sent < n_items) begin
            run  = {};
            kind = $urandom_range(99);
            if (kind < 30) begin
                do b = 8'($urandom_range(127)); while (b == CH_BACKSLASH);
                run.push_back(in_item_t'{b, 1'b0});
            end else if (kind < 45) begin
                run.push_back(in_item_t'{CH_BACKSLASH, 1'b0});
                run.push_back(in_item_t'{ESCAPE_CHARS[$urandom_range(7)], 1'b0});
            end else if (kind < 70) begin
                if (kind < 60)
                    unit = 16'($urandom);
                else
                    unit = 16'($urandom_range(16'hDBFF, 16'hD800));
                push_u_escape(run, unit);
                if (unit >= SURR_HIGH_MIN && unit <= SURR_HIGH_MAX) begin
                    if ($urandom_range(9) == 0)
                        unit = 16'($urandom);
                    else
                        unit = 16'($urandom_range(16'hDFFF, 16'hDC00));
                    push_u_escape(run, unit);
                end
            end else if (kind < 85) begin
                b = 8'($urandom_range(255, 128));
                run.push_back(in_item_t'{b, 1'b0});
                repeat (lead_cont(b))
                    run.push_back(in_item_t'{8'($urandom_range(8'hBF, 8'h80)), 1'b0});
            end else if (kind < 95) begin
                // escape followed by arbitrary bytes, hex digits or not
                run.push_back(in_item_t'{CH_BACKSLASH, 1'b0});
                repeat (5)
                    run.push_back(in_item_t'{8'($urandom), 1'b0});
            end else begin
                repeat ($urandom_range(3, 1))
                    run.push_back(in_item_t'{8'($urandom), 1'b0});
            end
            cut = $urandom_range(99);
            if (cut < 8)
                run[run.size()-1].token_end = 1'b1;
            else if (cut < 10)
                run[$urandom_range(run.size()-1)].token_end = 1'b1;
            foreach (run[k])
                send_byte(run[k]);
            sent += run.size();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            typed_rows.push_back(dir_table[i]);
            send_byte(dir_table[i].stim);
        end
        drain();

        random_tokens(130);
        drain();

        tx_idle_pct = 54;
        rx_idle_pct = 9;
        random_tokens(130);
        drain();

        // no idling; the long hold-off fills the job queue
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        random_tokens(125);
        drain();
        repeat (10) @(posedge aclk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ json_string_unescape_to_utf8_top.f @@
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_queue.sv
design/jsu_back.sv
design/json_string_unescape_to_utf8_top.sv
design/jsu_checker.sv
dv/testbench.sv
